### sv/bounded_set_min_gap_and_range_assert.svh
// Assertion macros for the bounded set min-gap and range tracker
`ifndef BOUNDED_SET_MIN_GAP_AND_RANGE_ASSERT_SVH
`define BOUNDED_SET_MIN_GAP_AND_RANGE_ASSERT_SVH

`ifndef SYNTH
// property checked at every clock edge outside reset
`define BSMG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// consequent checked in the cycle after the trigger
`define BSMG_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);
`else
`define BSMG_ASSERT(lbl, prop, msg)
`define BSMG_ASSERT_NEXT(lbl, trig, prop, msg)
`endif

`endif

### sv/bsmg_pkg.sv
// Types and constants of the bounded set min-gap and range tracker
package bsmg_pkg;

  localparam int CAPACITY  = 256;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int MAXC_W    = 9;
  localparam int SIZE_W    = 16;
  localparam int SUM_W     = ((CNT_W > SIZE_W) ? CNT_W : SIZE_W) + 1;
  localparam int VAL_W     = 32;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_NOFIT = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [VAL_W-1:0]  value;
    logic                     group_start;
    logic        [SIZE_W-1:0] group_size;
  } item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [8:0]       stored_count;
    logic [VAL_W-1:0] shortest_span;
    logic [VAL_W-1:0] longest_span;
    logic             spans_valid;
  } result_t;

  // Unsigned distance between two signed values, never overflows.
  function automatic logic [VAL_W-1:0] distance(logic signed [VAL_W-1:0] a,
                                                logic signed [VAL_W-1:0] b);
    logic [VAL_W-1:0] d;
    if (a < b) begin
      d = VAL_W'(b) - VAL_W'(a);
    end else begin
      d = VAL_W'(a) - VAL_W'(b);
    end
    return d;
  endfunction

endpackage

### sv/bounded_set_min_gap_and_range.sv
// Bounded set of signed values tracking the closest pair and the value range
//
// One result per accepted item, on result_o for a single cycle with
// result_valid_o; there is no back-pressure on results. An item that is
// rejected (store full, group does not fit, or dropped as part of a rejected
// group) shows its result on the next cycle, and busy stays low. An item that
// is stored passes through the scan, write-back and result states: the value
// store is a single-port synchronous RAM, so the scan reads one held value per
// cycle to fold its distance into the running minimum gap; once the read and
// distance pipeline registers have drained the scan ends, and the write-back
// state and then the result state follow, in which the result is registered.
// busy is high from the transfer until the result cycle ends, which also keeps
// a new item from reading the entry still being written. The max_count
// register takes writes while busy is low; the limit in force is the smaller
// of max_count and the store capacity of 256 entries.
module bounded_set_min_gap_and_range (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  bsmg_pkg::item_t      in_i,
  output logic                 result_valid_o,
  output bsmg_pkg::result_t    result_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [8:0]           cfg_data_i
);
  import bsmg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_FIN  = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [MAXC_W-1:0]       max_count_q;
  logic [CNT_W-1:0]        held_q;
  logic [VAL_W-1:0]        min_gap_q;
  logic signed [VAL_W-1:0] low_q, high_q;
  logic [SIZE_W-1:0]       rej_q, rej_d;
  logic signed [VAL_W-1:0] value_q;
  logic [CNT_W-1:0]        cnt_q;
  logic                    rd_vld_q, dist_vld_q;
  logic signed [VAL_W-1:0] rd_data_q;
  logic [VAL_W-1:0]        dist_q;
  logic [1:0]              status_d;
  logic                    store_d;
  logic                    accept;
  logic                    rd_en;
  logic                    emit;
  logic                    result_valid_q;
  result_t                 result_q, result_d;

  logic [SUM_W-1:0]        limit;
  logic [SUM_W-1:0]        held_ext;
  logic [SUM_W-1:0]        size_ext;

  logic signed [VAL_W-1:0] value_store [CAPACITY];

  assign accept      = start && (state_q == S_IDLE);
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);

  // Admission decision
  always_comb begin
    if (SUM_W'(max_count_q) < SUM_W'(CAPACITY)) begin
      limit = SUM_W'(max_count_q);
    end else begin
      limit = SUM_W'(CAPACITY);
    end
    held_ext = SUM_W'(held_q);
    size_ext = SUM_W'(in_i.group_size);
    status_d = ST_OK;
    store_d  = 1'b0;
    rej_d    = rej_q;
    if (in_i.group_start) begin
      rej_d = '0;
      if (in_i.group_size >= SIZE_W'(2)) begin
        if (held_ext + size_ext > limit) begin
          status_d = ST_NOFIT;
          rej_d    = in_i.group_size - SIZE_W'(1);
        end else begin
          store_d = 1'b1;
        end
      end else if (held_ext >= limit) begin
        status_d = ST_FULL;
      end else begin
        store_d = 1'b1;
      end
    end else if (rej_q != '0) begin
      status_d = ST_NOFIT;
      rej_d    = rej_q - SIZE_W'(1);
    end else if (held_ext >= limit) begin
      status_d = ST_FULL;
    end else begin
      store_d = 1'b1;
    end
  end

  assign rd_en = (state_q == S_SCAN) && (cnt_q < held_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && store_d) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!rd_en && !rd_vld_q && !dist_vld_q) begin
          state_d = S_FIN;
        end
      end
      S_FIN:   state_d = S_RESP;
      S_RESP:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Result from the current state; status comes from the decision or is OK
  assign emit = (accept && !store_d) || (state_q == S_RESP);

  always_comb begin
    result_d.status        = (state_q == S_RESP) ? ST_OK : status_d;
    result_d.stored_count  = 9'(held_q);
    result_d.spans_valid   = (held_q >= CNT_W'(2));
    result_d.shortest_span = result_d.spans_valid ? min_gap_q : '0;
    result_d.longest_span  = result_d.spans_valid ? (VAL_W'(high_q) - VAL_W'(low_q)) : '0;
  end

  // Value store: one write or one read a cycle, read data registered
  always_ff @(posedge clk_i) begin
    if (state_q == S_FIN) begin
      value_store[held_q[ADDR_W-1:0]] <= value_q;
    end
    if (rd_en) begin
      rd_data_q <= value_store[cnt_q[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      value_q <= in_i.value;
    end
    dist_q <= distance(value_q, rd_data_q);
    if (emit) begin
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      max_count_q    <= '0;
      held_q         <= '0;
      min_gap_q      <= '1;
      low_q          <= '0;
      high_q         <= '0;
      rej_q          <= '0;
      cnt_q          <= '0;
      rd_vld_q       <= 1'b0;
      dist_vld_q     <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      rd_vld_q       <= rd_en;
      dist_vld_q     <= rd_vld_q;
      result_valid_q <= emit;
      if (cfg_valid_i && cfg_ready_o) begin
        max_count_q <= cfg_data_i;
      end
      if (accept) begin
        rej_q <= rej_d;
        cnt_q <= '0;
      end else if (rd_en) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      // fold each held value's distance into the running minimum
      if (dist_vld_q && (dist_q < min_gap_q)) begin
        min_gap_q <= dist_q;
      end
      if (state_q == S_FIN) begin
        held_q <= held_q + CNT_W'(1);
        if (held_q == '0) begin
          low_q  <= value_q;
          high_q <= value_q;
        end else begin
          if (value_q < low_q) begin
            low_q <= value_q;
          end
          if (high_q < value_q) begin
            high_q <= value_q;
          end
        end
      end
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

`include "bounded_set_min_gap_and_range_assert.svh"

  `BSMG_ASSERT(a_write_in_range, (state_q != S_FIN) || (held_q < CNT_W'(CAPACITY)), "store write beyond capacity")
  `BSMG_ASSERT_NEXT(a_fin_counts, state_q == S_FIN, held_q == $past(held_q) + CNT_W'(1), "count not advanced after write-back")
  `BSMG_ASSERT_NEXT(a_scan_holds_count, state_q == S_SCAN, $stable(held_q), "count changed during scan")
  `BSMG_ASSERT(a_strobe_source, !result_valid_q || $past(emit), "result strobe without a finished item")

endmodule
